### sv/hmra_pkg.sv
package hmra_pkg;

  // Accumulator width of each motion axis
  localparam int ACC_WIDTH = 16;

  // Motion delta width on the input side
  localparam int DELTA_WIDTH = 16;

  // Report byte values
  localparam int AXIS_MAX = 127;
  localparam logic [2:0] REPORT_LEN = 3'd4;
  localparam logic [1:0] TOP_BUTTON = 2'd2;

  // Item kinds
  localparam logic [1:0] CMD_MOTION = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  // Poll answers
  localparam logic STATUS_REPORT = 1'b0;
  localparam logic STATUS_NAK = 1'b1;

  // Register file: one register, word-addressed by paddr[2]
  localparam int PADDR_WIDTH = 3;
  localparam logic REG_DEVICE_CONNECTED = 1'b0;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [DELTA_WIDTH-1:0] delta_x;
    logic signed [DELTA_WIDTH-1:0] delta_y;
    logic signed [DELTA_WIDTH-1:0] delta_z;
    logic [1:0] button_index;
    logic button_pressed;
    logic [6:0] poll_len;
  } in_item_t;

  typedef struct packed {
    logic poll_status;
    logic [2:0] report_buttons;
    logic signed [7:0] report_x;
    logic signed [7:0] report_y;
    logic signed [7:0] report_z;
    logic [2:0] report_bytes;
  } out_item_t;

endpackage

### sv/hid_mouse_report_accumulator.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_ready  in_data (in_item_t)
// out       result     out_valid/out_ready  out_data (out_item_t), polls only
// apb       config     psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// One item per cycle while no poll waits on a stalled result register. Each item
// passes the input register, where the accumulators and buttons update; a poll's
// answer is then registered in the result register.
// Synchronous reset clears the state and both valid flags; device_connected
// resets to 1. A poll waits in the input register while the result register
// is stalled, and nothing enters behind it; events never wait on the result side.
module hid_mouse_report_accumulator
  import hmra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int SUM_W = ((ACC_WIDTH > DELTA_WIDTH) ? ACC_WIDTH : DELTA_WIDTH) + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_AXIS_MAX = ACC_WIDTH'(AXIS_MAX);
  localparam logic signed [ACC_WIDTH-1:0] ACC_AXIS_MIN = -ACC_AXIS_MAX;

  // Add a delta and saturate at the accumulator range
  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [DELTA_WIDTH-1:0] d
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    lo = ~hi;
    s = SUM_W'(a) + SUM_W'(d);
    if (s > hi) begin
      return hi[ACC_WIDTH-1:0];
    end else if (s < lo) begin
      return lo[ACC_WIDTH-1:0];
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  // Clamp an accumulator to one report byte
  function automatic logic signed [ACC_WIDTH-1:0] clamp_axis(
    input logic signed [ACC_WIDTH-1:0] a
  );
    if (a > ACC_AXIS_MAX) begin
      return ACC_AXIS_MAX;
    end else if (a < ACC_AXIS_MIN) begin
      return ACC_AXIS_MIN;
    end
    return a;
  endfunction

  logic device_connected;
  logic [2:0] button_state;
  logic signed [ACC_WIDTH-1:0] accum_x;
  logic signed [ACC_WIDTH-1:0] accum_y;
  logic signed [ACC_WIDTH-1:0] accum_z;
  logic report_pending;

  logic s1_valid;
  in_item_t s1_item;

  logic [2:0] button_state_next;
  logic signed [ACC_WIDTH-1:0] accum_x_next;
  logic signed [ACC_WIDTH-1:0] accum_y_next;
  logic signed [ACC_WIDTH-1:0] accum_z_next;
  logic report_pending_next;
  out_item_t result_next;

  logic signed [ACC_WIDTH-1:0] clx;
  logic signed [ACC_WIDTH-1:0] cly;
  logic signed [ACC_WIDTH-1:0] clz;
  logic s1_is_poll;
  logic s1_adv;
  logic cfg_write;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DEVICE_CONNECTED) ? {31'b0, device_connected} : 32'b0;

  // Handshake: advance the input register unless it holds a poll and the result register is full
  assign s1_is_poll = (s1_item.cmd == CMD_POLL);
  assign s1_adv = s1_valid && (!s1_is_poll || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign clx = clamp_axis(accum_x);
  assign cly = clamp_axis(accum_y);
  assign clz = clamp_axis(accum_z);

  // Work out the next state and the poll answer
  always_comb begin
    button_state_next = button_state;
    accum_x_next = accum_x;
    accum_y_next = accum_y;
    accum_z_next = accum_z;
    report_pending_next = report_pending;
    result_next = '0;
    result_next.poll_status = STATUS_NAK;
    case (s1_item.cmd)
      CMD_MOTION: begin
        if (device_connected && (s1_item.delta_x != '0 || s1_item.delta_y != '0 ||
                                 s1_item.delta_z != '0)) begin
          accum_x_next = sat_add(accum_x, s1_item.delta_x);
          accum_y_next = sat_add(accum_y, s1_item.delta_y);
          accum_z_next = sat_add(accum_z, s1_item.delta_z);
          report_pending_next = 1'b1;
        end
      end
      CMD_BUTTON: begin
        if (device_connected && s1_item.button_index <= TOP_BUTTON) begin
          button_state_next[s1_item.button_index] = s1_item.button_pressed;
          if (button_state_next != button_state) begin
            report_pending_next = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        if (report_pending) begin
          accum_x_next = accum_x - clx;
          accum_y_next = accum_y - cly;
          accum_z_next = accum_z - clz;
          report_pending_next = (clx != '0) || (cly != '0) || (clz != '0) ||
                                (accum_x_next != '0) || (accum_y_next != '0) ||
                                (accum_z_next != '0);
          result_next.poll_status = STATUS_REPORT;
          result_next.report_buttons = button_state;
          result_next.report_x = clx[7:0];
          result_next.report_y = cly[7:0];
          result_next.report_z = clz[7:0];
          result_next.report_bytes = (s1_item.poll_len >= 7'(REPORT_LEN)) ?
                                     REPORT_LEN : s1_item.poll_len[2:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control state, the input register and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_connected <= 1'b1;
      button_state <= '0;
      accum_x <= '0;
      accum_y <= '0;
      accum_z <= '0;
      report_pending <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_DEVICE_CONNECTED) begin
        device_connected <= pwdata[0];
      end
      if (s1_adv) begin
        button_state <= button_state_next;
        accum_x <= accum_x_next;
        accum_y <= accum_y_next;
        accum_z <= accum_z_next;
        report_pending <= report_pending_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv && s1_is_poll) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (s1_adv && s1_is_poll) begin
      out_data <= result_next;
    end
  end

  // A NAK carries no report
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.poll_status == STATUS_NAK |->
      out_data.report_buttons == '0 && out_data.report_x == '0 &&
      out_data.report_y == '0 && out_data.report_z == '0 &&
      out_data.report_bytes == '0)
    else $error("NAK result carries report data");

  // Delivered axes stay within one report byte and length within the report
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.report_x != 8'sh80 && out_data.report_y != 8'sh80 &&
      out_data.report_z != 8'sh80 && out_data.report_bytes <= REPORT_LEN)
    else $error("report field outside its range");

  // Nothing pending means no motion left in the accumulators
  assert property (@(posedge clk) disable iff (rst)
    !report_pending |-> accum_x == '0 && accum_y == '0 && accum_z == '0)
    else $error("motion left with no report pending");

endmodule

### tb/hmra_report_checker.sv
`timescale 1ns / 1ps

module hmra_report_checker
  import hmra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     mismatches,
  output int                     waiting
);

  localparam logic [PADDR_WIDTH-1:0] CONNECTED_ADDR = {REG_DEVICE_CONNECTED, 2'b00};

  // Shadow of the device state
  logic                          connected;
  logic [2:0]                    buttons_held;
  logic signed [ACC_WIDTH-1:0]   axis_acc [3];
  logic                          report_due;

  // Poll answers still owed by the block, oldest first
  out_item_t                     expected_reports [$];
  int                            fault_count = 0;

  // Add a delta and pin the sum to the signed accumulator range
  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0]   acc,
    input logic signed [DELTA_WIDTH-1:0] delta
  );
    longint hi;
    longint lo;
    longint sum;
    hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    lo = -hi - 1;
    sum = longint'(acc) + longint'(delta);
    if (sum > hi) return ACC_WIDTH'(hi);
    if (sum < lo) return ACC_WIDTH'(lo);
    return ACC_WIDTH'(sum);
  endfunction

  // Limit an accumulator to what one report byte can carry
  function automatic logic signed [ACC_WIDTH-1:0] clamp_axis(
    input logic signed [ACC_WIDTH-1:0] v
  );
    if (v > AXIS_MAX) return ACC_WIDTH'(AXIS_MAX);
    if (v < -AXIS_MAX) return ACC_WIDTH'(-AXIS_MAX);
    return v;
  endfunction

  // Advance the shadow state by one request; queue the answer for a poll
  task automatic apply_request(input in_item_t req);
    logic signed [DELTA_WIDTH-1:0] delta [3];
    logic signed [ACC_WIDTH-1:0]   step [3];
    logic [2:0]                    held_next;
    logic                          moved;
    logic                          residual;
    out_item_t                     rep;
    delta[0] = req.delta_x;
    delta[1] = req.delta_y;
    delta[2] = req.delta_z;
    case (req.cmd)
      CMD_MOTION: begin
        if (connected && (delta[0] != 0 || delta[1] != 0 || delta[2] != 0)) begin
          for (int a = 0; a < 3; a++) axis_acc[a] = sat_add(axis_acc[a], delta[a]);
          report_due = 1'b1;
        end
      end
      CMD_BUTTON: begin
        if (connected && req.button_index <= TOP_BUTTON) begin
          held_next = buttons_held;
          held_next[req.button_index] = req.button_pressed;
          if (held_next != buttons_held) report_due = 1'b1;
          buttons_held = held_next;
        end
      end
      CMD_POLL: begin
        rep = '0;
        if (!report_due) begin
          rep.poll_status = STATUS_NAK;
        end else begin
          moved = 1'b0;
          residual = 1'b0;
          for (int a = 0; a < 3; a++) begin
            step[a] = clamp_axis(axis_acc[a]);
            axis_acc[a] = axis_acc[a] - step[a];
            moved = moved | (step[a] != 0);
            residual = residual | (axis_acc[a] != 0);
          end
          // stay due while motion is left, or to follow a move with a still report
          report_due = moved | residual;
          rep.poll_status = STATUS_REPORT;
          rep.report_buttons = buttons_held;
          rep.report_x = step[0][7:0];
          rep.report_y = step[1][7:0];
          rep.report_z = step[2][7:0];
          rep.report_bytes = (req.poll_len < REPORT_LEN) ? req.poll_len[2:0] : REPORT_LEN;
        end
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(
    input string              name,
    input logic signed [31:0] want,
    input logic signed [31:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Watch all three ports at each edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      connected = 1'b1;
      buttons_held = '0;
      for (int a = 0; a < 3; a++) axis_acc[a] = '0;
      report_due = 1'b0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with no poll outstanding");
          fault_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("poll_status", want.poll_status, out_data.poll_status);
          compare_field("report_buttons", want.report_buttons, out_data.report_buttons);
          compare_field("report_x", want.report_x, out_data.report_x);
          compare_field("report_y", want.report_y, out_data.report_y);
          compare_field("report_z", want.report_z, out_data.report_z);
          compare_field("report_bytes", want.report_bytes, out_data.report_bytes);
        end
      end
      if (psel && penable && pwrite && pready && paddr == CONNECTED_ADDR) begin
        connected = pwdata[0];
      end
      if (in_valid && in_ready) apply_request(in_data);
    end
    mismatches <= fault_count;
    waiting <= expected_reports.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench
  import hmra_pkg::*;
();

  localparam logic [1:0]             CMD_UNUSED = 2'd3;
  localparam logic [PADDR_WIDTH-1:0] CONNECTED_ADDR = {REG_DEVICE_CONNECTED, 2'b00};
  localparam int                     IDLE_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int                     mismatches;
  int                     waiting;
  int                     quiet_cycles = 0;
  int                     stall_left = 0;
  bit                     rx_calm = 1'b0;
  bit                     tx_calm = 1'b0;

  hid_mouse_report_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  hmra_report_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Stall the report side at random, with calm stretches in between
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_pause() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t motion_req(input int dx, input int dy, input int dz);
    in_item_t r;
    r = '0;
    r.cmd = CMD_MOTION;
    r.delta_x = DELTA_WIDTH'(dx);
    r.delta_y = DELTA_WIDTH'(dy);
    r.delta_z = DELTA_WIDTH'(dz);
    return r;
  endfunction

  function automatic in_item_t button_req(input int idx, input bit pressed);
    in_item_t r;
    r = '0;
    r.cmd = CMD_BUTTON;
    r.button_index = 2'(idx);
    r.button_pressed = pressed;
    return r;
  endfunction

  function automatic in_item_t poll_req(input int len);
    in_item_t r;
    r = '0;
    r.cmd = CMD_POLL;
    r.poll_len = 7'(len);
    return r;
  endfunction

  // Small moves most of the time, some large ones and the range ends
  function automatic logic signed [DELTA_WIDTH-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DELTA_WIDTH'(int'($urandom_range(0, 300)) - 150);
    if (r < 70) return '0;
    if (r < 85) return DELTA_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
    if (r < 95) return DELTA_WIDTH'($urandom_range(0, 65535));
    return DELTA_WIDTH'($urandom_range(0, 1) ? 32767 : -32768);
  endfunction

  function automatic logic [6:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 7'($urandom_range(0, 3));
    if (r < 40) return 7'd64;
    return 7'($urandom_range(4, 63));
  endfunction

  // Random request; fields the kind does not use carry random values too
  function automatic in_item_t random_request();
    in_item_t r;
    int       kind;
    r.delta_x = DELTA_WIDTH'($urandom_range(0, 65535));
    r.delta_y = DELTA_WIDTH'($urandom_range(0, 65535));
    r.delta_z = DELTA_WIDTH'($urandom_range(0, 65535));
    r.button_index = 2'($urandom_range(0, 3));
    r.button_pressed = 1'($urandom_range(0, 1));
    r.poll_len = 7'($urandom_range(0, 64));
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      r.cmd = CMD_MOTION;
      if ($urandom_range(0, 19) == 0) begin
        r.delta_x = '0;
        r.delta_y = '0;
        r.delta_z = '0;
      end else begin
        r.delta_x = pick_delta();
        r.delta_y = pick_delta();
        r.delta_z = pick_delta();
      end
    end else if (kind < 55) begin
      r.cmd = CMD_BUTTON;
    end else begin
      r.cmd = CMD_POLL;
      r.poll_len = pick_len();
    end
    return r;
  endfunction

  // Offer one request and hold it until taken
  task automatic push_request(input in_item_t req);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off until every poll has been answered and the pipeline is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_connected(input logic value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CONNECTED_ADDR;
    pwdata <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_random(input int count);
    in_item_t req;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (i % 300 == 299) drain_results();
      // slip in an unknown command now and then
      if ($urandom_range(0, 49) == 0) begin
        req = random_request();
        req.cmd = CMD_UNUSED;
        push_request(req);
      end
      push_request(random_request());
    end
  endtask

  initial begin
    in_item_t directed [$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // NAK on an idle device, then a single button press and its report
    directed.push_back(poll_req(64));
    directed.push_back(button_req(0, 1'b1));
    directed.push_back(poll_req(4));
    directed.push_back(poll_req(4));
    // press again without change, and the unused button index
    directed.push_back(button_req(0, 1'b1));
    directed.push_back(poll_req(7));
    directed.push_back(button_req(3, 1'b1));
    directed.push_back(poll_req(2));
    // still motion is dropped
    directed.push_back(motion_req(0, 0, 0));
    directed.push_back(poll_req(64));
    // drive the accumulators into both rails
    directed.push_back(motion_req(32767, -32768, 5));
    directed.push_back(motion_req(32767, -32768, -5));
    directed.push_back(poll_req(0));
    directed.push_back(poll_req(3));
    directed.push_back(button_req(2, 1'b1));
    directed.push_back(button_req(1, 1'b1));
    directed.push_back(motion_req(-32768, 32767, 0));
    directed.push_back(poll_req(1));
    directed.push_back(in_item_t'({CMD_UNUSED, 58'h2AA_5555_AAAA_5555}));
    directed.push_back(motion_req(-300, 300, 1));
    directed.push_back(poll_req(64));
    directed.push_back(button_req(0, 1'b0));
    directed.push_back(poll_req(5));
    directed.push_back(poll_req(63));
    foreach (directed[i]) push_request(directed[i]);

    // disconnected: events dropped, polls still answered
    write_connected(1'b0);
    run_random(40);
    write_connected(1'b1);
    run_random(480);
    write_connected(1'b0);
    run_random(30);
    write_connected(1'b1);
    run_random(480);

    drain_results();
    repeat (10) @(posedge clk);
    if (waiting != 0) $error("%0d polls left without a report", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/hmra_pkg.sv
sv/hid_mouse_report_accumulator.sv
tb/hmra_report_checker.sv
tb/testbench.sv
